>>> rtl/skoc_pkg.sv
// Package for the soft-knee offset clamp: payload structs, fixed widths,
// tanh/exp constants and the end-to-end pipeline latency.
// No dependencies.
package skoc_pkg;

  // Fixed field formats
  localparam int CoordWidth = 32;
  localparam int LimWidth   = CoordWidth - 1;
  localparam int FracBits   = 16;
  localparam int FracWidth  = 16;

  // Register map
  localparam logic       RegFracIdx    = 1'b0;
  localparam logic [15:0] FractionReset = 16'd36045;

  // 0.70 in Q0.16, and the knee threshold that stands for 1e-6
  localparam logic [15:0] KneeQ16 = 16'd45875;
  localparam int          KneeMin = (1 << FracBits) / 1000000;

  // Q.30 tanh arithmetic
  localparam int          Tf          = 30;
  localparam int          TaylorTerms = 16;
  localparam int          SatShift    = 4;
  localparam logic [30:0] TOne        = 31'h4000_0000;
  // exp(-1) from the truncated Taylor sum, Q.30
  localparam logic [28:0] ExpNegOne   = 29'd395007543;

  // ceil(2^34 / n) for n = 1..16: exact floor(x / n) for x < 2^30
  localparam logic [34:0] RecipM [TaylorTerms] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
    35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
    35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766,
    35'd1321528399,  35'd1227133514, 35'd1145324613, 35'd1073741824
  };

  // Cycles from an accepted item to the edge that takes its result
  localparam int Lat = 205;

  typedef struct packed {
    logic signed [CoordWidth-1:0] offset_x;
    logic signed [CoordWidth-1:0] offset_y;
    logic signed [CoordWidth-1:0] offset_z;
    logic        [LimWidth-1:0]   local_radius;
    logic signed [CoordWidth-1:0] ring_gap_limit;
  } skoc_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] clamped_x;
    logic signed [CoordWidth-1:0] clamped_y;
    logic signed [CoordWidth-1:0] clamped_z;
  } skoc_out_t;

endpackage

>>> rtl/skoc_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
// Standalone; no package needed.
module skoc_sqrt_pipe #(
  parameter int RW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o
);

  logic            v_q    [1:RW];
  logic [RW+1:0]   rem_q  [1:RW];
  logic [RW-1:0]   root_q [1:RW];
  logic [2*RW-1:0] rad_q  [1:RW];

  for (genvar s = 1; s <= RW; s++) begin : g_stage
    logic            prev_v;
    logic [RW+1:0]   prev_rem;
    logic [RW-1:0]   prev_root;
    logic [2*RW-1:0] prev_rad;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic            ge;

    if (s == 1) begin : g_first
      assign prev_v    = valid_i;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_rad  = rad_i;
    end else begin : g_next
      assign prev_v    = v_q[s-1];
      assign prev_rem  = rem_q[s-1];
      assign prev_root = root_q[s-1];
      assign prev_rad  = rad_q[s-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {prev_rem, prev_rad[2*RW-1 -: 2]};
    assign trial = (RW+4)'({prev_root, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (RW+2)'(cur - trial) : cur[RW+1:0];
      root_q[s] <= {prev_root[RW-2:0], ge};
      rad_q[s]  <= {prev_rad[2*RW-3:0], 2'b00};
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = root_q[RW];

endmodule

>>> rtl/skoc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; no package needed. The caller supplies a starting remainder below den_i.
module skoc_div_pipe #(
  parameter int QW = 32,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o
);

  logic          v_q   [1:QW];
  logic [DW-1:0] rem_q [1:QW];
  logic [QW-1:0] num_q [1:QW];
  logic [DW-1:0] den_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic          prev_v;
    logic [DW-1:0] prev_rem;
    logic [QW-1:0] prev_num;
    logic [DW-1:0] prev_den;
    logic [QW-1:0] prev_quo;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 1) begin : g_first
      assign prev_v   = valid_i;
      assign prev_rem = rem_i;
      assign prev_num = num_i;
      assign prev_den = den_i;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_v   = v_q[s-1];
      assign prev_rem = rem_q[s-1];
      assign prev_num = num_q[s-1];
      assign prev_den = den_q[s-1];
      assign prev_quo = quo_q[s-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    assign trial = {prev_rem, prev_num[QW-1]};
    assign ge    = trial >= {1'b0, prev_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(trial - {1'b0, prev_den}) : trial[DW-1:0];
      num_q[s] <= {prev_num[QW-2:0], 1'b0};
      den_q[s] <= prev_den;
      quo_q[s] <= {prev_quo[QW-2:0], ge};
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = quo_q[QW];

endmodule

>>> rtl/soft_knee_offset_clamp.sv
// Top level of the soft-knee offset clamp: tanh length limiter for 3D offsets.
// Depends on skoc_pkg, skoc_sqrt_pipe and skoc_div_pipe.
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+----------------------
//   item in   | start & !busy at a rising edge    | item_i (skoc_in_t)
//   result    | done_o, one cycle, taken at edge  | result_o (skoc_out_t)
//   config    | APB write: psel&penable&pwrite    | pwdata, paddr[2]
//
// One item enters every cycle; busy stays low. Each item passes through 6
// setup stages, a 33-stage square root, an excess stage, a 34-stage ratio
// divider, 32 Taylor stages, 31 exp(-1) stages, a tanh setup stage, a
// 31-stage tanh divider, 3 scaling stages, a 32-stage component divider and
// the output register. The receiver cannot stall the pipeline.
// Reset clears the valid bits and restores max_radius_fraction.
module soft_knee_offset_clamp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  skoc_pkg::skoc_in_t    item_i,
  output logic                  busy,
  output logic                  done_o,
  output skoc_pkg::skoc_out_t   result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import skoc_pkg::*;

  localparam int W       = CoordWidth;
  localparam int LW      = LimWidth;
  localparam int SqW     = 2 * W + 2;
  localparam int RootW   = W + 1;
  localparam int Q1W     = Tf + SatShift;
  localparam int Q2W     = Tf + 1;
  localparam int ExpLat  = 2 * TaylorTerms;
  localparam int KmulLat = 31;

  typedef struct packed {
    logic [2:0][W-1:0] mag;
    logic [2:0]        neg;
    logic              bypass;
    logic [LW-1:0]     knee;
    logic [LW-1:0]     rng;
  } side_t;

  typedef struct packed {
    logic [2:0][W-1:0] mag;
    logic [2:0]        neg;
    logic              bypass;
    logic [LW-1:0]     knee;
    logic [LW-1:0]     rng;
    logic [W-1:0]      len;
    logic              sat;
  } side2_t;

  typedef struct packed {
    side2_t      side;
    logic [29:0] f;
    logic [4:0]  k;
    logic [30:0] term;
    logic [30:0] sum;
    logic [29:0] x;
  } ex_t;

  typedef struct packed {
    side2_t      side;
    logic [4:0]  k;
    logic [30:0] e;
  } km_t;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register
  logic [FracWidth-1:0] frac_q;
  logic                 cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FractionReset;
    end else if (cfg_wr && (paddr[2] == RegFracIdx)) begin
      frac_q <= pwdata[FracWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == RegFracIdx) ? {{(32-FracWidth){1'b0}}, frac_q} : '0;

  // Stage A: split components into sign and magnitude
  logic [2:0][W-1:0] in_vec;
  logic              a_v_q;
  logic [2:0][W-1:0] a_mag_q;
  logic [2:0]        a_neg_q;
  logic [LW-1:0]     a_rad_q;
  logic [W-1:0]      a_gap_q;

  assign in_vec[0] = item_i.offset_x;
  assign in_vec[1] = item_i.offset_y;
  assign in_vec[2] = item_i.offset_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_neg_q[i] <= in_vec[i][W-1];
      a_mag_q[i] <= in_vec[i][W-1] ? W'(-in_vec[i]) : in_vec[i];
    end
    a_rad_q <= item_i.local_radius;
    a_gap_q <= item_i.ring_gap_limit;
  end

  // Stage B: radius times fraction, component squares
  logic                       b_v_q;
  logic [LW+FracWidth-1:0]    b_rprod_q;
  logic [2*W-1:0]             b_sq_q [3];
  logic [2:0][W-1:0]          b_mag_q;
  logic [2:0]                 b_neg_q;
  logic [W-1:0]               b_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rprod_q <= (LW+FracWidth)'(a_rad_q) * (LW+FracWidth)'(frac_q);
    for (int i = 0; i < 3; i++) begin
      b_sq_q[i] <= (2*W)'(a_mag_q[i]) * (2*W)'(a_mag_q[i]);
    end
    b_mag_q <= a_mag_q;
    b_neg_q <= a_neg_q;
    b_gap_q <= a_gap_q;
  end

  // Stage C: limit and squared length
  logic              c_v_q;
  logic [LW-1:0]     c_limit_q;
  logic [SqW-1:0]    c_sq_q;
  logic [2:0][W-1:0] c_mag_q;
  logic [2:0]        c_neg_q;
  logic [LW-1:0]     rlim;

  assign rlim = b_rprod_q[LW+FracWidth-1:FracWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_gap_q[W-1]) begin
      c_limit_q <= '0;
    end else begin
      c_limit_q <= (b_gap_q[LW-1:0] < rlim) ? b_gap_q[LW-1:0] : rlim;
    end
    c_sq_q  <= SqW'(b_sq_q[0]) + SqW'(b_sq_q[1]) + SqW'(b_sq_q[2]);
    c_mag_q <= b_mag_q;
    c_neg_q <= b_neg_q;
  end

  // Stage D: limit times 0.70
  logic              d_v_q;
  logic [LW+15:0]    d_kprod_q;
  logic [LW-1:0]     d_limit_q;
  logic [SqW-1:0]    d_sq_q;
  logic [2:0][W-1:0] d_mag_q;
  logic [2:0]        d_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_kprod_q <= (LW+16)'(c_limit_q) * (LW+16)'(KneeQ16);
    d_limit_q <= c_limit_q;
    d_sq_q    <= c_sq_q;
    d_mag_q   <= c_mag_q;
    d_neg_q   <= c_neg_q;
  end

  // Stage E: knee, knee squared, range
  logic              e_v_q;
  logic [2*LW-1:0]   e_ksq_q;
  logic [LW-1:0]     e_knee_q;
  logic [LW-1:0]     e_rng_q;
  logic [SqW-1:0]    e_sq_q;
  logic [2:0][W-1:0] e_mag_q;
  logic [2:0]        e_neg_q;
  logic [LW-1:0]     knee;

  assign knee = d_kprod_q[LW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_ksq_q  <= (2*LW)'(knee) * (2*LW)'(knee);
    e_knee_q <= knee;
    e_rng_q  <= d_limit_q - knee;
    e_sq_q   <= d_sq_q;
    e_mag_q  <= d_mag_q;
    e_neg_q  <= d_neg_q;
  end

  // Stage F: decide the pass-through cases
  logic           f_v_q;
  side_t          f_side_q;
  logic [SqW-1:0] f_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_side_q.mag    <= e_mag_q;
    f_side_q.neg    <= e_neg_q;
    f_side_q.knee   <= e_knee_q;
    f_side_q.rng    <= e_rng_q;
    f_side_q.bypass <= (e_knee_q <= LW'(KneeMin)) || (e_sq_q <= SqW'(e_ksq_q));
    f_sq_q          <= e_sq_q;
  end

  // Square root of the squared length
  logic             sq_v;
  logic [RootW-1:0] sq_root;
  side_t            sq_dly_q [RootW];

  skoc_sqrt_pipe #(.RW(RootW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v_q),
    .rad_i   (f_sq_q),
    .valid_o (sq_v),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    sq_dly_q[0] <= f_side_q;
    for (int i = 1; i < RootW; i++) begin
      sq_dly_q[i] <= sq_dly_q[i-1];
    end
  end

  // Stage G: excess over the knee and saturation check
  logic         g_v_q;
  side2_t       g_side_q;
  logic [W-1:0] g_exc_q;
  side_t        sq_side;
  logic [W-1:0] len;
  logic [W-1:0] excess;

  assign sq_side = sq_dly_q[RootW-1];
  assign len     = sq_root[W-1:0];
  assign excess  = len - W'(sq_side.knee);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else begin
      g_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    g_side_q.mag    <= sq_side.mag;
    g_side_q.neg    <= sq_side.neg;
    g_side_q.bypass <= sq_side.bypass;
    g_side_q.knee   <= sq_side.knee;
    g_side_q.rng    <= sq_side.rng;
    g_side_q.len    <= len;
    g_side_q.sat    <= (LW+SatShift)'(excess) >= {sq_side.rng, {SatShift{1'b0}}};
    g_exc_q         <= excess;
  end

  // Ratio excess / range in Q.30
  logic           d1_v;
  logic [Q1W-1:0] d1_q;
  side2_t         d1_dly_q [Q1W];

  skoc_div_pipe #(.QW(Q1W), .DW(LW)) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_v_q),
    .rem_i   (LW'(g_exc_q[W-1:SatShift])),
    .num_i   ({g_exc_q[SatShift-1:0], {Tf{1'b0}}}),
    .den_i   (g_side_q.rng),
    .valid_o (d1_v),
    .quo_o   (d1_q)
  );

  always_ff @(posedge clk_i) begin
    d1_dly_q[0] <= g_side_q;
    for (int i = 1; i < Q1W; i++) begin
      d1_dly_q[i] <= d1_dly_q[i-1];
    end
  end

  // Taylor sum of exp(-f), two stages per term
  logic ex_v_q [1:ExpLat];
  ex_t  ex_q   [1:ExpLat];

  for (genvar s = 1; s <= ExpLat; s++) begin : g_exp
    localparam int N = (s + 1) / 2;
    logic prev_v;
    ex_t  prev;
    ex_t  nxt;

    if (s == 1) begin : g_first
      assign prev_v    = d1_v;
      assign prev.side = d1_dly_q[Q1W-1];
      assign prev.f    = {d1_q[Tf-2:0], 1'b0};
      assign prev.k    = d1_q[Q1W-1:Tf-1];
      assign prev.term = TOne;
      assign prev.sum  = TOne;
      assign prev.x    = '0;
    end else begin : g_next
      assign prev_v = ex_v_q[s-1];
      assign prev   = ex_q[s-1];
    end

    if (s % 2 == 1) begin : g_mul
      // Multiply the running term by f
      logic [60:0] prod;
      assign prod = 61'(prev.term) * 61'(prev.f);
      always_comb begin
        nxt   = prev;
        nxt.x = prod[59:30];
      end
    end else begin : g_div
      // Divide by the term index, then fold into the sum
      logic [64:0] qp;
      logic [29:0] tq;
      assign qp = 65'(prev.x) * 65'(RecipM[N-1]);
      assign tq = qp[63:34];
      always_comb begin
        nxt      = prev;
        nxt.term = {1'b0, tq};
        nxt.sum  = (N % 2 == 1) ? prev.sum - 31'(tq) : prev.sum + 31'(tq);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_v_q[s] <= 1'b0;
      end else begin
        ex_v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      ex_q[s] <= nxt;
    end
  end

  // Apply exp(-1) once per integer unit of 2r
  logic km_v_q [1:KmulLat];
  km_t  km_q   [1:KmulLat];

  for (genvar s = 1; s <= KmulLat; s++) begin : g_kmul
    localparam logic [4:0] Idx = 5'(s - 1);
    logic        prev_v;
    km_t         prev;
    logic [59:0] prod;
    logic [60:0] rnd;

    if (s == 1) begin : g_first
      assign prev_v    = ex_v_q[ExpLat];
      assign prev.side = ex_q[ExpLat].side;
      assign prev.k    = ex_q[ExpLat].k;
      assign prev.e    = ex_q[ExpLat].sum;
    end else begin : g_next
      assign prev_v = km_v_q[s-1];
      assign prev   = km_q[s-1];
    end

    assign prod = 60'(prev.e) * 60'(ExpNegOne);
    assign rnd  = 61'(prod) + 61'(TOne >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        km_v_q[s] <= 1'b0;
      end else begin
        km_v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      km_q[s].side <= prev.side;
      km_q[s].k    <= prev.k;
      km_q[s].e    <= (Idx < prev.k) ? rnd[60:30] : prev.e;
    end
  end

  // Form the tanh numerator and denominator
  logic        t_v_q;
  side2_t      t_side_q;
  logic [31:0] t_rem_q;
  logic [30:0] t_low_q;
  logic [31:0] t_den_q;
  logic [31:0] den;
  logic [30:0] diff;
  logic [61:0] tnum;

  assign den  = 32'(TOne) + 32'(km_q[KmulLat].e);
  assign diff = TOne - km_q[KmulLat].e;
  assign tnum = {diff, {Tf{1'b0}}} + 62'(den >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else begin
      t_v_q <= km_v_q[KmulLat];
    end
  end

  always_ff @(posedge clk_i) begin
    t_side_q <= km_q[KmulLat].side;
    t_rem_q  <= 32'(tnum[61:31]);
    t_low_q  <= tnum[30:0];
    t_den_q  <= den;
  end

  // tanh quotient in Q.30
  logic           d2_v;
  logic [Q2W-1:0] d2_q;
  side2_t         d2_dly_q [Q2W];

  skoc_div_pipe #(.QW(Q2W), .DW(32)) u_div_tanh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_v_q),
    .rem_i   (t_rem_q),
    .num_i   (t_low_q),
    .den_i   (t_den_q),
    .valid_o (d2_v),
    .quo_o   (d2_q)
  );

  always_ff @(posedge clk_i) begin
    d2_dly_q[0] <= t_side_q;
    for (int i = 1; i < Q2W; i++) begin
      d2_dly_q[i] <= d2_dly_q[i-1];
    end
  end

  // Stage P: range times tanh
  logic        p_v_q;
  side2_t      p_side_q;
  logic [61:0] p_q;
  side2_t      d2_side;
  logic [30:0] tanh_val;

  assign d2_side  = d2_dly_q[Q2W-1];
  assign tanh_val = d2_side.sat ? TOne : d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    p_side_q <= d2_side;
    p_q      <= 62'(d2_side.rng) * 62'(tanh_val);
  end

  // Stage S: soft length, capped at the true length
  logic         s_v_q;
  side2_t       s_side_q;
  logic [W-1:0] s_soft_q;
  logic [W:0]   soft_sum;

  assign soft_sum = (W+1)'(p_side_q.knee) + (W+1)'(p_q[61:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_side_q <= p_side_q;
    s_soft_q <= (soft_sum > (W+1)'(p_side_q.len)) ? p_side_q.len : soft_sum[W-1:0];
  end

  // Stage M: scale each magnitude by the soft length
  logic           m_v_q;
  side2_t         m_side_q;
  logic [2*W-1:0] m_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q <= s_side_q;
    for (int i = 0; i < 3; i++) begin
      m_prod_q[i] <= (2*W)'(s_side_q.mag[i]) * (2*W)'(s_soft_q);
    end
  end

  // Divide each scaled magnitude by the length
  logic [2:0]        d3_v;
  logic [2:0][W-1:0] d3_q;
  side2_t            d3_dly_q [W];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    skoc_div_pipe #(.QW(W), .DW(W)) u_div_comp (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (m_v_q),
      .rem_i   (m_prod_q[c][2*W-1:W]),
      .num_i   (m_prod_q[c][W-1:0]),
      .den_i   (m_side_q.len),
      .valid_o (d3_v[c]),
      .quo_o   (d3_q[c])
    );
  end

  always_ff @(posedge clk_i) begin
    d3_dly_q[0] <= m_side_q;
    for (int i = 1; i < W; i++) begin
      d3_dly_q[i] <= d3_dly_q[i-1];
    end
  end

  // Output register: restore signs, pass through where bypassed
  side2_t            d3_side;
  logic [2:0][W-1:0] out_mag;
  logic [2:0][W-1:0] out_vec;
  logic              done_q;
  skoc_out_t         result_q;

  assign d3_side = d3_dly_q[W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_mag[i] = d3_side.bypass ? d3_side.mag[i] : d3_q[i];
      out_vec[i] = d3_side.neg[i] ? W'(-out_mag[i]) : out_mag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= &d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.clamped_x <= out_vec[0];
    result_q.clamped_y <= out_vec[1];
    result_q.clamped_z <= out_vec[2];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> rtl/skoc_checker.sv
// Port-level checks for the soft-knee offset clamp, bound to the top level.
// Depends on skoc_pkg and soft_knee_offset_clamp.
module skoc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input skoc_pkg::skoc_in_t  item_i,
  input logic                done_o,
  input skoc_pkg::skoc_out_t result_o,
  input logic [31:0]         prdata
);

  import skoc_pkg::*;

  // Every result comes from a matching earlier transfer
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without matching item");

  // Every transfer yields its result
  a_item_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("item lost in pipeline");

  // A zero vector stays zero
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && item_i.offset_x == '0 && item_i.offset_y == '0
                     && item_i.offset_z == '0, Lat))
    |-> (result_o.clamped_x == '0 && result_o.clamped_y == '0
         && result_o.clamped_z == '0))
    else $error("zero vector changed");

  // Only the low 16 bits of readback carry the fraction
  a_prdata_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:16] == 16'h0000)
    else $error("readback upper bits set");

endmodule

bind soft_knee_offset_clamp skoc_checker u_skoc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o),
  .prdata   (prdata)
);
